>>> sv/mrf_pkg.sv
`timescale 1ns / 1ps

package mrf_pkg;

	// Frame geometry: six header and data bytes, then two CRC bytes.
	localparam int FrameBytes = 8;
	localparam int DataBytes  = 6;
	localparam int IdxW       = $clog2(FrameBytes);

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [15:0] CoilOn  = 16'hFF00;
	localparam logic [15:0] CoilOff = 16'h0000;

	// Request kinds as they arrive on the request channel.
	typedef enum logic [1:0] {
		KIND_READ_HOLDING = 2'd0,
		KIND_READ_INPUT   = 2'd1,
		KIND_WRITE_COIL   = 2'd2,
		KIND_WRITE_REG    = 2'd3
	} kind_t;

	// Modbus function codes.
	localparam logic [7:0] FcReadHolding = 8'h03;
	localparam logic [7:0] FcReadInput   = 8'h04;
	localparam logic [7:0] FcWriteCoil   = 8'h05;
	localparam logic [7:0] FcWriteReg    = 8'h06;

	typedef logic [IdxW-1:0] idx_t;

	// Byte positions within the frame that are handled specially.
	localparam idx_t CrcLoIdx = idx_t'(DataBytes);
	localparam idx_t LastIdx  = idx_t'(FrameBytes - 1);

	// Byte i of the frame sits at element i.
	typedef logic [DataBytes-1:0][7:0] frame_data_t;

	// Encoded request held in the input stage.
	typedef struct packed {
		logic        valid;
		frame_data_t data;
	} req_s1_t;

	// Serialiser state seen by the input stage and the top level.
	typedef struct packed {
		logic load_ready;
		logic busy;
		logic emit;
		idx_t idx;
	} ser_status_t;

	// One byte of CRC-16/MODBUS, reflected, eight shift steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/mrf_req_if.sv
`timescale 1ns / 1ps

interface mrf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  slave_id;
	logic [15:0] address;
	logic [15:0] value;

	modport source (output valid, output kind, output slave_id, output address,
		output value, input ready);
	modport sink (input valid, input kind, input slave_id, input address,
		input value, output ready);
endinterface

>>> sv/mrf_byte_if.sv
`timescale 1ns / 1ps

interface mrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink (input valid, input frame_byte, input last, output ready);
endinterface

>>> sv/mrf_request_stage.sv
`timescale 1ns / 1ps

module mrf_request_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	mrf_req_if.sink              req,
	input  mrf_pkg::ser_status_t status,
	output mrf_pkg::req_s1_t     req_s1
);

	logic                  valid_s1;
	mrf_pkg::frame_data_t  data_s1;
	mrf_pkg::frame_data_t  data_d;
	logic [7:0]            fc;
	logic [15:0]           word;
	logic                  take;

	// The stage is free when empty or when the serialiser takes its content.
	assign req.ready = !valid_s1 || status.load_ready;
	assign take      = req.valid && req.ready;

	// Function code and data word from the request kind.
	always_comb begin
		fc   = mrf_pkg::FcReadHolding;
		word = req.value;
		unique case (req.kind)
			mrf_pkg::KIND_READ_HOLDING: begin
				fc   = mrf_pkg::FcReadHolding;
				word = req.value;
			end
			mrf_pkg::KIND_READ_INPUT: begin
				fc   = mrf_pkg::FcReadInput;
				word = req.value;
			end
			mrf_pkg::KIND_WRITE_COIL: begin
				fc   = mrf_pkg::FcWriteCoil;
				word = (req.value != 16'h0000) ? mrf_pkg::CoilOn : mrf_pkg::CoilOff;
			end
			mrf_pkg::KIND_WRITE_REG: begin
				fc   = mrf_pkg::FcWriteReg;
				word = req.value;
			end
			default: begin
				fc   = mrf_pkg::FcReadHolding;
				word = req.value;
			end
		endcase
	end

	// Frame bytes in transmit order, big-endian address and word.
	always_comb begin
		data_d[0] = req.slave_id;
		data_d[1] = fc;
		data_d[2] = req.address[15:8];
		data_d[3] = req.address[7:0];
		data_d[4] = word[15:8];
		data_d[5] = word[7:0];
	end

	// Occupancy of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (status.load_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Encoded request payload.
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_d;
		end
	end

	assign req_s1.valid = valid_s1;
	assign req_s1.data  = data_s1;

endmodule

>>> sv/mrf_serialiser.sv
`timescale 1ns / 1ps

module mrf_serialiser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrf_pkg::req_s1_t     req_s1,
	output mrf_pkg::ser_status_t status,
	mrf_byte_if.source           frame
);

	logic                  busy_q;
	mrf_pkg::idx_t         idx_q;
	mrf_pkg::frame_data_t  data_q;
	logic [15:0]           crc_q;
	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  last_q;
	logic                  out_free;
	logic                  emit;
	logic                  load_ready;
	logic                  load;
	logic                  in_data;
	logic [7:0]            next_byte;

	// A byte moves into the output register when it is empty or being drained.
	assign out_free   = !out_valid_q || frame.ready;
	assign emit       = busy_q && out_free;
	assign load_ready = !busy_q || (emit && (idx_q == mrf_pkg::LastIdx));
	assign load       = req_s1.valid && load_ready;
	assign in_data    = idx_q < mrf_pkg::CrcLoIdx;

	// Byte selection: stored bytes first, then the CRC low and high bytes.
	always_comb begin
		if (in_data) begin
			next_byte = data_q[idx_q];
		end else if (idx_q == mrf_pkg::CrcLoIdx) begin
			next_byte = crc_q[7:0];
		end else begin
			next_byte = crc_q[15:8];
		end
	end

	// Frame position and output occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				busy_q <= (idx_q != mrf_pkg::LastIdx);
				idx_q  <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame bytes, running CRC and the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= req_s1.data;
			crc_q  <= mrf_pkg::CrcInit;
		end else if (emit && in_data) begin
			crc_q <= mrf_pkg::crc_feed(crc_q, next_byte);
		end
		if (emit) begin
			byte_q <= next_byte;
			last_q <= (idx_q == mrf_pkg::LastIdx);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last       = last_q;

	assign status.load_ready = load_ready;
	assign status.busy       = busy_q;
	assign status.emit       = emit;
	assign status.idx        = idx_q;

endmodule

>>> sv/modbus_rtu_request_framer_unit.sv
`timescale 1ns / 1ps

// Modbus RTU request framer.
// The req channel takes one request beat: kind, slave_id, address and value.
// The frame channel returns eight beats per request in transmit order: slave
// id, function code, address high and low, data word high and low, then the
// CRC-16/MODBUS low and high bytes; last is set on the CRC high byte only.
// A request is encoded into the input stage on acceptance; the serialiser
// loads it on the next cycle when idle, and the first byte then passes from
// the frame registers into the output register. The CRC is updated one byte
// per cycle while the receiver is ready, as the data bytes leave, and the
// next request is loaded in the same cycle as the previous frame's last
// byte, so a waiting request follows without a gap.
// The input stage holds one request while a frame is being sent, so a new
// request is taken without waiting for the output to drain.
// When the receiver holds ready low the output beat stays put, the
// serialiser pauses and, once the input stage is full, req.ready drops.
// Reset clears all valid flags; no frame is in flight afterwards.
module modbus_rtu_request_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	mrf_req_if.sink     req,
	mrf_byte_if.source  frame
);

	mrf_pkg::req_s1_t     req_s1;
	mrf_pkg::ser_status_t status;

	mrf_request_stage u_request_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.status (status),
		.req_s1 (req_s1)
	);

	mrf_serialiser u_serialiser (
		.clk    (clk),
		.arst_n (arst_n),
		.req_s1 (req_s1),
		.status (status),
		.frame  (frame)
	);

`ifndef SYNTHESIS
	// Sending the CRC high byte produces a last beat on the next cycle.
	a_last_follows_crc_hi: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit && (status.idx == mrf_pkg::LastIdx) |=> frame.valid && frame.last)
		else $error("last beat missing after CRC high byte");

	// A loaded request starts at the first frame byte.
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		status.load_ready && req_s1.valid |=> status.busy && (status.idx == '0))
		else $error("serialiser did not restart on load");

	// While a last beat waits, the serialiser is idle or at a fresh frame.
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.last |-> (status.idx == '0))
		else $error("frame position not wrapped after last beat");
`endif

endmodule
